// File: src/ftsc_pkg.sv
// shared types, signature tables and type codes for the file type classifier
package ftsc_pkg;

	// header length in bytes
	localparam int unsigned HEADER_BYTES = 50;
	localparam int unsigned SIG_COUNT = 17;
	localparam int unsigned SIG_MAX_LEN = 16;
	localparam int unsigned POS_W = 6;

	typedef enum logic [4:0] {
		TC_UNKNOWN = 5'd0,
		TC_TXT     = 5'd1,
		TC_HTML    = 5'd2,
		TC_AVI     = 5'd3,
		TC_CCF     = 5'd4,
		TC_CWS     = 5'd5,
		TC_FLAC    = 5'd6,
		TC_FLV     = 5'd7,
		TC_GIF     = 5'd8,
		TC_FWS     = 5'd9,
		TC_JPG     = 5'd10,
		TC_MP4     = 5'd11,
		TC_PAR2    = 5'd12,
		TC_PDF     = 5'd13,
		TC_PNG     = 5'd14,
		TC_PK      = 5'd15,
		TC_RAR     = 5'd16,
		TC_WAV     = 5'd17,
		TC_WMA     = 5'd18
	} type_code_t;

	// per-file classification state
	typedef struct packed {
		logic [POS_W-1:0]     pos;
		logic                 all_text;
		logic [SIG_COUNT-1:0] match;
		logic                 waiting;
	} ftsc_state_t;

	// one result item
	typedef struct packed {
		type_code_t type_code;
		logic       is_text;
	} ftsc_res_t;

	localparam ftsc_state_t STATE_RESET = '{
		pos: '0, all_text: 1'b1, match: '1, waiting: 1'b0};

	// signature 0 is html, the rest are in priority order
	localparam type_code_t SIG_CODE [SIG_COUNT] = '{
		TC_HTML, TC_AVI, TC_CCF, TC_CWS, TC_FLAC, TC_FLV, TC_GIF, TC_FWS, TC_JPG,
		TC_MP4, TC_PAR2, TC_PDF, TC_PNG, TC_PK, TC_RAR, TC_WAV, TC_WMA};

	// first header position of each signature
	localparam logic [POS_W-1:0] SIG_OFF [SIG_COUNT] = '{
		6'd0, 6'd8, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd4, 6'd0, 6'd1, 6'd1, 6'd0, 6'd0, 6'd8, 6'd0};

	// one past the last header position of each signature
	localparam logic [POS_W-1:0] SIG_END [SIG_COUNT] = '{
		6'd14, 6'd11, 6'd4, 6'd3, 6'd4, 6'd3, 6'd3, 6'd3, 6'd3,
		6'd11, 6'd4, 6'd4, 6'd4, 6'd2, 6'd3, 6'd15, 6'd16};

	localparam logic [7:0] SIG_BYTES [SIG_COUNT][SIG_MAX_LEN] = '{
		'{8'h3C, 8'h21, 8'h44, 8'h4F, 8'h43, 8'h54, 8'h59, 8'h50,
		  8'h45, 8'h20, 8'h48, 8'h54, 8'h4D, 8'h4C, 8'h00, 8'h00},
		'{8'h41, 8'h56, 8'h49, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'hC3, 8'hCA, 8'h04, 8'hC1, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h43, 8'h57, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h66, 8'h4C, 8'h61, 8'h43, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h46, 8'h4C, 8'h56, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h47, 8'h49, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h46, 8'h57, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h66, 8'h74, 8'h79, 8'h70, 8'h6D, 8'h70, 8'h34, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h41, 8'h52, 8'h32, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h44, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h4E, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h4B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h52, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h57, 8'h41, 8'h56, 8'h45, 8'h66, 8'h6D, 8'h74, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h30, 8'h26, 8'hB2, 8'h75, 8'h8E, 8'h66, 8'hCF, 8'h11,
		  8'hA6, 8'hD9, 8'h00, 8'hAA, 8'h00, 8'h62, 8'hCE, 8'h6C}
	};

endpackage

// File: src/file_type_signature_classifier.sv
// top level of the file type classifier: input stage, state and result register
//
// Usage: the bytes of one file stream in on the slave channel, one byte per item,
// s_tdata the byte, s_tuser set when the byte is real (clear for a bare end
// marker), s_tlast on the last item of the file. The first 50 header bytes are
// checked for text and for fixed signatures; one result item with the type code
// and the text flag leaves on the master channel when the header is complete or
// the file ends, whichever is first. A short file is judged as if padded with
// zero bytes. After the result, bytes are dropped until s_tlast.
// An accepted item is held in the input stage, then classified into the
// result register that drives m_tvalid. Throughput: one item per cycle
// while s_tready is high; the per-byte update is a single pass of byte
// compares against the signature table and the position counter.
// Reset clears the input stage, the result register and the per-file state,
// so the next item starts a new file. When the receiver stalls, the result is
// held and one more item still enters the input stage; s_tready drops only
// when both the input stage and the result register are occupied.
module file_type_signature_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] byte_valid
	input  logic       s_tlast,   // end_of_file
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [4:0] type_code, [5] is_text, [7:6] zero
);
	import ftsc_pkg::*;

	logic        item_vld_s1;
	logic [7:0]  data_s1;
	logic        user_s1;
	logic        last_s1;
	logic        m_valid_q;
	ftsc_res_t   res_q;
	ftsc_state_t state_q;
	ftsc_state_t next_state;
	ftsc_res_t   res;
	logic        emit;
	logic        advance;

	// the input stage moves on when the result register is free or drains
	assign advance  = !m_valid_q || m_tready;
	assign s_tready = !item_vld_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			item_vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			user_s1 <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	ftsc_step u_step (
		.state       (state_q),
		.data_byte   (data_s1),
		.byte_valid  (user_s1),
		.end_of_file (last_s1),
		.next_state  (next_state),
		.emit        (emit),
		.res         (res)
	);

	// per-file state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (item_vld_s1 && advance) begin
			state_q <= next_state;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= item_vld_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_vld_s1 && emit) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, res_q.is_text, res_q.type_code};

endmodule

// File: src/ftsc_step.sv
// per-item next-state and result logic of the file type classifier
module ftsc_step (
	input  ftsc_pkg::ftsc_state_t state,
	input  logic [7:0]            data_byte,
	input  logic                  byte_valid,
	input  logic                  end_of_file,
	output ftsc_pkg::ftsc_state_t next_state,
	output logic                  emit,
	output ftsc_pkg::ftsc_res_t   res
);
	import ftsc_pkg::*;

	logic                 take;
	logic                 byte_text;
	logic [POS_W-1:0]     pos1;
	logic                 at1;
	logic [SIG_COUNT-1:0] m1;
	logic [SIG_COUNT-1:0] m_pad;
	logic                 header_done;
	logic                 res_text;
	logic [SIG_COUNT-1:0] res_match;

	// text test on the incoming byte
	always_comb begin
		byte_text = ((data_byte >= 8'd33) && (data_byte <= 8'd127)) || (data_byte == 8'd9) ||
			(data_byte == 8'd10) || (data_byte == 8'd13) || (data_byte == 8'd32);
	end

	// take one header byte: update text flag, signature matches and position
	always_comb begin
		logic [POS_W-1:0] rel;
		rel  = '0;
		take = byte_valid && (state.pos < POS_W'(HEADER_BYTES));
		pos1 = state.pos;
		at1  = state.all_text;
		m1   = state.match;
		if (take) begin
			pos1 = state.pos + POS_W'(1);
			at1  = state.all_text && byte_text;
			for (int k = 0; k < SIG_COUNT; k++) begin
				rel = state.pos - SIG_OFF[k];
				if ((state.pos >= SIG_OFF[k]) && (state.pos < SIG_END[k]) &&
					(data_byte != SIG_BYTES[k][rel[3:0]])) begin
					m1[k] = 1'b0;
				end
			end
		end
	end

	// zero padding of a short file keeps only signatures already complete
	always_comb begin
		for (int k = 0; k < SIG_COUNT; k++) begin
			m_pad[k] = m1[k] && (pos1 >= SIG_END[k]);
		end
	end

	assign header_done = (pos1 >= POS_W'(HEADER_BYTES));

	// control: emit on full header or early end, then reset or skip
	always_comb begin
		emit       = 1'b0;
		next_state = state;
		res_text   = at1;
		res_match  = m1;
		if (state.waiting) begin
			if (end_of_file) begin
				next_state = STATE_RESET;
			end
		end else if (header_done) begin
			emit = 1'b1;
			if (end_of_file) begin
				next_state = STATE_RESET;
			end else begin
				next_state = '{pos: pos1, all_text: at1, match: m1, waiting: 1'b1};
			end
		end else if (end_of_file) begin
			emit       = 1'b1;
			res_text   = 1'b0;
			res_match  = m_pad;
			next_state = STATE_RESET;
		end else begin
			next_state = '{pos: pos1, all_text: at1, match: m1, waiting: 1'b0};
		end
	end

	// type code: html or txt for text, else first surviving signature
	always_comb begin
		res.is_text   = res_text;
		res.type_code = TC_UNKNOWN;
		if (res_text) begin
			res.type_code = res_match[0] ? TC_HTML : TC_TXT;
		end else begin
			for (int k = SIG_COUNT - 1; k >= 1; k--) begin
				if (res_match[k]) begin
					res.type_code = SIG_CODE[k];
				end
			end
		end
	end

endmodule

// File: src/ftsc_checker.sv
// port-level checks for the file type classifier, bound to the top level
module ftsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);
	import ftsc_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// the text flag goes only with txt or html
	a_text_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5] == ((m_tdata[4:0] == TC_TXT) || (m_tdata[4:0] == TC_HTML))))
		else $error("text flag and type code disagree");

	// type code in range and padding bits zero
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4:0] <= TC_WMA) && (m_tdata[7:6] == 2'b00))
		else $error("type code out of range");

	// with an empty result register the input side is always open
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with no result pending");

endmodule

bind file_type_signature_classifier ftsc_checker u_ftsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: sim/file_type_signature_classifier_tb.sv
// self-checking testbench for the file type classifier: directed short files, then random files
module file_type_signature_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ftsc_pkg::*;

	localparam int SIG_N = 17;
	localparam int HDR_LEN = ftsc_pkg::HEADER_BYTES;
	localparam int RANDOM_ITEMS = 650;

	// where each signature starts in the header and how long it is
	localparam int SIG_AT [SIG_N] = '{0, 8, 0, 0, 0, 0, 0, 0, 0, 4, 0, 1, 1, 0, 0, 8, 0};
	localparam int SIG_LEN [SIG_N] = '{14, 3, 4, 3, 4, 3, 3, 3, 3, 7, 4, 3, 3, 2, 3, 7, 16};
	localparam type_code_t SIG_TYPE [SIG_N] = '{
		TC_HTML, TC_AVI, TC_CCF, TC_CWS, TC_FLAC, TC_FLV, TC_GIF, TC_FWS, TC_JPG,
		TC_MP4, TC_PAR2, TC_PDF, TC_PNG, TC_PK, TC_RAR, TC_WAV, TC_WMA};

	typedef struct packed {
		type_code_t code;
		logic       text;
	} verdict_t;

	typedef struct {
		logic [7:0] data;
		logic       valid;
		logic       last;
		bit         pinned;
		type_code_t code;
		logic       text;
	} stim_row_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tuser = 1'b0;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;

	// file classification state of the predictor
	int unsigned      hdr_pos;
	logic             hdr_all_text;
	logic [SIG_N-1:0] hdr_match;
	logic             hdr_skipping;

	verdict_t verdicts_due [$];
	verdict_t pin_res;
	int       err_count = 0;
	int       items_sent = 0;
	int       files_sent = 0;
	int       verdicts_checked = 0;
	logic [18:0] codes_seen = '0;
	int       src_idle_pct = 18;
	int       sink_idle_pct = 61;

	// short directed files: empty, bare markers, short signatures, single extreme bytes
	stim_row_t dir_rows [25] = '{
		'{8'h00, 1'b0, 1'b0, 1'b0, TC_UNKNOWN, 1'b0},
		'{8'h00, 1'b0, 1'b1, 1'b1, TC_UNKNOWN, 1'b0},
		'{8'h47, 1'b1, 1'b0, 1'b0, TC_UNKNOWN, 1'b0},
		'{8'h49, 1'b1, 1'b0, 1'b0, TC_UNKNOWN, 1'b0},
		'{8'h46, 1'b1, 1'b1, 1'b1, TC_GIF,     1'b0},
		'{8'h50, 1'b1, 1'b0, 1'b0, TC_UNKNOWN, 1'b0},
		'{8'h4B, 1'b1, 1'b1, 1'b1, TC_PK,      1'b0},
		'{8'hFF, 1'b1, 1'b0, 1'b0, TC_UNKNOWN, 1'b0},
		'{8'hD8, 1'b1, 1'b0, 1'b0, TC_UNKNOWN, 1'b0},
		'{8'hFF, 1'b1, 1'b1, 1'b1, TC_JPG,     1'b0},
		'{8'hC3, 1'b1, 1'b0, 1'b0, TC_UNKNOWN, 1'b0},
		'{8'hCA, 1'b1, 1'b0, 1'b0, TC_UNKNOWN, 1'b0},
		'{8'h04, 1'b1, 1'b0, 1'b0, TC_UNKNOWN, 1'b0},
		'{8'hC1, 1'b1, 1'b1, 1'b1, TC_CCF,     1'b0},
		'{8'hFF, 1'b1, 1'b1, 1'b1, TC_UNKNOWN, 1'b0},
		'{8'h00, 1'b1, 1'b1, 1'b1, TC_UNKNOWN, 1'b0},
		'{8'h50, 1'b1, 1'b0, 1'b0, TC_UNKNOWN, 1'b0},
		'{8'h00, 1'b0, 1'b1, 1'b0, TC_UNKNOWN, 1'b0},
		'{8'h52, 1'b1, 1'b0, 1'b0, TC_UNKNOWN, 1'b0},
		'{8'h61, 1'b1, 1'b0, 1'b0, TC_UNKNOWN, 1'b0},
		'{8'h5A, 1'b0, 1'b0, 1'b0, TC_UNKNOWN, 1'b0},
		'{8'h72, 1'b1, 1'b1, 1'b1, TC_RAR,     1'b0},
		'{8'h46, 1'b1, 1'b0, 1'b0, TC_UNKNOWN, 1'b0},
		'{8'h57, 1'b1, 1'b0, 1'b0, TC_UNKNOWN, 1'b0},
		'{8'h53, 1'b1, 1'b1, 1'b1, TC_FWS,     1'b0}
	};

	file_type_signature_classifier dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// overall time limit
	initial begin
		#2ms;
		$display("timeout at %0t with %0d results outstanding", $realtime, verdicts_due.size());
		$display("file_type_signature_classifier test failed");
		$finish;
	end

	// byte i of signature k
	function automatic logic [7:0] sig_char(int k, int i);
		logic [127:0] pat;
		case (k)
			0:       pat = "<!DOCTYPE HTML";
			1:       pat = "AVI";
			2:       pat = 32'hC3CA04C1;
			3:       pat = "CWS";
			4:       pat = "fLaC";
			5:       pat = "FLV";
			6:       pat = "GIF";
			7:       pat = "FWS";
			8:       pat = 24'hFFD8FF;
			9:       pat = "ftypmp4";
			10:      pat = "PAR2";
			11:      pat = "PDF";
			12:      pat = "PNG";
			13:      pat = "PK";
			14:      pat = "Rar";
			15:      pat = "WAVEfmt";
			default: pat = 128'h3026B2758E66CF11A6D900AA0062CE6C;
		endcase
		return pat[8*(SIG_LEN[k]-1-i) +: 8];
	endfunction

	function automatic bit printable(logic [7:0] b);
		return (b >= 8'd33 && b <= 8'd127) || b == 8'd9 || b == 8'd10 || b == 8'd13 ||
			b == 8'd32;
	endfunction

	function automatic void clear_file();
		hdr_pos = 0;
		hdr_all_text = 1'b1;
		hdr_match = '1;
		hdr_skipping = 1'b0;
	endfunction

	// fold one header byte into the text flag and the signature matches
	function automatic void absorb_byte(logic [7:0] b);
		int unsigned p;
		p = hdr_pos;
		if (!printable(b))
			hdr_all_text = 1'b0;
		for (int k = 0; k < SIG_N; k++) begin
			if (p >= SIG_AT[k] && p < SIG_AT[k] + SIG_LEN[k] && b != sig_char(k, p - SIG_AT[k]))
				hdr_match[k] = 1'b0;
		end
		hdr_pos = (p + 1) & 63;
	endfunction

	// text wins, otherwise the lowest matching signature index
	function automatic verdict_t judge_header();
		verdict_t r;
		r.text = hdr_all_text;
		r.code = TC_UNKNOWN;
		if (hdr_all_text) begin
			r.code = hdr_match[0] ? TC_HTML : TC_TXT;
		end else begin
			for (int k = SIG_N - 1; k >= 1; k--)
				if (hdr_match[k])
					r.code = SIG_TYPE[k];
		end
		return r;
	endfunction

	// next classifier state for one item; returns 1 when a type code is due
	function automatic bit classify_item(logic [7:0] b, logic v, logic l, output verdict_t res);
		res = '{TC_UNKNOWN, 1'b0};
		if (hdr_skipping) begin
			if (l)
				clear_file();
			return 1'b0;
		end
		if (v && hdr_pos < HDR_LEN)
			absorb_byte(b);
		if (hdr_pos >= HDR_LEN) begin
			res = judge_header();
			if (l)
				clear_file();
			else
				hdr_skipping = 1'b1;
			return 1'b1;
		end
		if (l) begin
			while (hdr_pos < HDR_LEN)
				absorb_byte(8'h00);
			res = judge_header();
			clear_file();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// drive one item at the falling edge and hold it until accepted
	task automatic send_item(logic [7:0] b, logic v, logic l, bit pinned = 1'b0,
			verdict_t pinned_res = '0);
		verdict_t res;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= v;
		s_tlast <= l;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (classify_item(b, v, l, res))
			verdicts_due.push_back(pinned ? pinned_res : res);
		if (v || l)
			items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] text_char();
		case ($urandom_range(0, 11))
			0:       return 8'd9;
			1:       return 8'd10;
			2:       return 8'd13;
			3:       return 8'd32;
			default: return 8'($urandom_range(33, 127));
		endcase
	endfunction

	// one random file, mostly well formed around a signature or text
	task automatic send_file();
		logic [7:0] body [64];
		int kind, sig, alt, len, r;
		bit textual, bare_end;
		kind = $urandom_range(0, 9);
		textual = (kind == 6 || kind == 7) ? 1'b1 : ($urandom_range(0, 2) == 0);
		for (int i = 0; i < 64; i++)
			body[i] = textual ? text_char() : 8'($urandom);
		sig = $urandom_range(1, SIG_N - 1);
		len = 50 + $urandom_range(0, 6);
		if (kind <= 5 || kind == 8) begin
			// one signature, or two with the second laid over the first
			if (kind == 8) begin
				alt = $urandom_range(1, SIG_N - 1);
				for (int i = 0; i < SIG_LEN[alt]; i++)
					body[SIG_AT[alt] + i] = sig_char(alt, i);
			end
			for (int i = 0; i < SIG_LEN[sig]; i++)
				body[SIG_AT[sig] + i] = sig_char(sig, i);
			if ($urandom_range(0, 4) == 0) begin
				r = SIG_AT[sig] + $urandom_range(0, SIG_LEN[sig] - 1);
				body[r] = body[r] ^ (8'h01 << $urandom_range(0, 7));
			end
			case ($urandom_range(0, 3))
				0:       len = $urandom_range(0, 49);
				1, 2:    len = SIG_AT[sig] + SIG_LEN[sig] + $urandom_range(0, 4);
				default: len = 50 + $urandom_range(0, 6);
			endcase
		end else if (kind == 6 || kind == 7) begin
			// text or html, sometimes spoiled by one binary byte
			if (kind == 6)
				for (int i = 0; i < SIG_LEN[0]; i++)
					body[i] = sig_char(0, i);
			if ($urandom_range(0, 4) == 0)
				body[$urandom_range(0, 49)] = ($urandom_range(0, 1) == 1) ?
					8'($urandom_range(128, 255)) : 8'($urandom_range(0, 8));
			if ($urandom_range(0, 5) == 0)
				len = $urandom_range(0, 49);
		end else begin
			len = $urandom_range(0, 60);
		end
		bare_end = (len == 0) || ($urandom_range(0, 4) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(body[i], 1'b1, !bare_end && i == len - 1);
		end
		if (bare_end)
			send_item(8'($urandom), 1'b0, 1'b1);
		files_sent++;
	endtask

	// receiver readiness changes at the falling edge
	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

	// compare each result item with the oldest expected type code
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdicts_due.size() == 0) begin
				err_count++;
				$display("%0t unexpected result: got code %0d text %0d", $realtime,
					m_tdata[4:0], m_tdata[5]);
			end else begin
				want = verdicts_due.pop_front();
				verdicts_checked++;
				codes_seen[want.code] = 1'b1;
				if (m_tdata[4:0] !== want.code || m_tdata[5] !== want.text ||
						m_tdata[7:6] !== 2'b00) begin
					err_count++;
					$display("%0t mismatch: expected code %0d text %0d, got code %0d text %0d pad %b",
						$realtime, want.code, want.text, m_tdata[4:0], m_tdata[5],
						m_tdata[7:6]);
				end
			end
		end
	end

	// reset, directed rows, random files in three idling phases, drain
	initial begin
		clear_file();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			pin_res.code = dir_rows[i].code;
			pin_res.text = dir_rows[i].text;
			send_item(dir_rows[i].data, dir_rows[i].valid, dir_rows[i].last,
				dir_rows[i].pinned, pin_res);
		end
		files_sent += 10;

		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent < RANDOM_ITEMS / 3) begin
				src_idle_pct = 18;
				sink_idle_pct = 61;
			end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
				src_idle_pct = 61;
				sink_idle_pct = 18;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			send_file();
		end
		s_tvalid <= 1'b0;

		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d files in %0d items, checked %0d type codes", files_sent, items_sent,
			verdicts_checked);
		$display("distinct type codes seen: %0d of 19", $countones(codes_seen));
		if (err_count == 0) begin
			$display("file_type_signature_classifier test passed");
		end else begin
			$display("%0d errors", err_count);
			$display("file_type_signature_classifier test failed");
		end
		$finish;
	end

endmodule
